/* rtl/hcc_pkg.sv */
// Shared constants, request and response types and class codes of the HSV colour classifier.
package hcc_pkg;

   localparam int CHANNEL_BITS = 10;
   localparam int FRAC_BITS    = 16;
   localparam int HUE_FRAC     = 7;
   localparam int FIELD_BITS   = 10;
   localparam int HUE_BITS     = 16;

   // Quotient bits of the shared divider: enough for Q0.FRAC_BITS with a carry and for hue.
   localparam int QUO_W      = (FRAC_BITS + 1 > HUE_BITS) ? FRAC_BITS + 1 : HUE_BITS;
   localparam int DVD_W      = CHANNEL_BITS + QUO_W;
   localparam int NUM_W      = CHANNEL_BITS + 9;
   localparam int DIV_STAGES = QUO_W;

   localparam logic [CHANNEL_BITS-1:0] SCALE_HI     = {CHANNEL_BITS{1'b1}};
   localparam logic [CHANNEL_BITS-1:0] SCALE_LO     = CHANNEL_BITS'(255);
   localparam logic [CHANNEL_BITS:0]   SCALE_SWITCH = (CHANNEL_BITS + 1)'(320);

   // floor(s / 3) for s below 3 * 2^CHANNEL_BITS as (s * 2731) >> 13.
   localparam int MEAN_MUL_W = 12;
   localparam logic [MEAN_MUL_W-1:0] MEAN_MUL = MEAN_MUL_W'(2731);
   localparam int MEAN_SHIFT = 13;

   localparam logic [FRAC_BITS-1:0] QMAX = {FRAC_BITS{1'b1}};

   localparam logic [FRAC_BITS-1:0] THR_15 = FRAC_BITS'((15 * (2 ** FRAC_BITS)) / 100);
   localparam logic [FRAC_BITS-1:0] THR_18 = FRAC_BITS'((18 * (2 ** FRAC_BITS)) / 100);
   localparam logic [FRAC_BITS-1:0] THR_30 = FRAC_BITS'((30 * (2 ** FRAC_BITS)) / 100);
   localparam logic [FRAC_BITS-1:0] THR_35 = FRAC_BITS'((35 * (2 ** FRAC_BITS)) / 100);
   localparam logic [FRAC_BITS-1:0] THR_50 = FRAC_BITS'((50 * (2 ** FRAC_BITS)) / 100);
   localparam logic [FRAC_BITS-1:0] THR_55 = FRAC_BITS'((55 * (2 ** FRAC_BITS)) / 100);
   localparam logic [FRAC_BITS-1:0] THR_75 = FRAC_BITS'((75 * (2 ** FRAC_BITS)) / 100);

   localparam logic [HUE_BITS-1:0] DEG_25  = HUE_BITS'(25 * (2 ** HUE_FRAC));
   localparam logic [HUE_BITS-1:0] DEG_60  = HUE_BITS'(60 * (2 ** HUE_FRAC));
   localparam logic [HUE_BITS-1:0] DEG_70  = HUE_BITS'(70 * (2 ** HUE_FRAC));
   localparam logic [HUE_BITS-1:0] DEG_170 = HUE_BITS'(170 * (2 ** HUE_FRAC));
   localparam logic [HUE_BITS-1:0] DEG_190 = HUE_BITS'(190 * (2 ** HUE_FRAC));
   localparam logic [HUE_BITS-1:0] DEG_260 = HUE_BITS'(260 * (2 ** HUE_FRAC));
   localparam logic [HUE_BITS-1:0] DEG_290 = HUE_BITS'(290 * (2 ** HUE_FRAC));
   localparam logic [HUE_BITS-1:0] DEG_335 = HUE_BITS'(335 * (2 ** HUE_FRAC));
   localparam logic [HUE_BITS-1:0] DEG_359 = HUE_BITS'(359 * (2 ** HUE_FRAC));

   localparam int ADDR_W = 3;
   localparam logic REG_BLACK_MODE = 1'b0;

   typedef enum logic [2:0] {
      CLS_RED     = 3'd0,
      CLS_YELLOW  = 3'd1,
      CLS_GREEN   = 3'd2,
      CLS_BLUE    = 3'd3,
      CLS_WHITE   = 3'd4,
      CLS_BLACK   = 3'd5,
      CLS_UNKNOWN = 3'd6
   } color_class_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] red_raw;
      logic [FIELD_BITS-1:0] green_raw;
      logic [FIELD_BITS-1:0] blue_raw;
      logic [FIELD_BITS-1:0] ambient_raw;
   } req_type;

   typedef struct packed {
      color_class_type       color_class;
      logic [HUE_BITS-1:0]   hue_deg;
      logic [FRAC_BITS-1:0]  saturation;
      logic [FRAC_BITS-1:0]  brightness_value;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic env_hi;
      logic gray;
      logic dark;
   } side_type;

endpackage

/* rtl/hcc_divider.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module hcc_divider (
   input  logic                             clock,
   input  logic                             enable,
   input  logic [hcc_pkg::DVD_W-1:0]        dividend,
   input  logic [hcc_pkg::CHANNEL_BITS-1:0] divisor,
   output logic [hcc_pkg::QUO_W-1:0]        quotient
);

   logic [hcc_pkg::CHANNEL_BITS-1:0] rem_ff [0:hcc_pkg::DIV_STAGES-1];
   logic [hcc_pkg::CHANNEL_BITS-1:0] rem_in [0:hcc_pkg::DIV_STAGES-1];
   logic [hcc_pkg::QUO_W-1:0]        quo_ff [0:hcc_pkg::DIV_STAGES-1];
   logic [hcc_pkg::QUO_W-1:0]        quo_in [0:hcc_pkg::DIV_STAGES-1];
   logic [hcc_pkg::QUO_W-1:0]        low_ff [0:hcc_pkg::DIV_STAGES-1];
   logic [hcc_pkg::QUO_W-1:0]        low_in [0:hcc_pkg::DIV_STAGES-1];
   logic [hcc_pkg::CHANNEL_BITS-1:0] dsr_ff [0:hcc_pkg::DIV_STAGES-1];
   logic [hcc_pkg::CHANNEL_BITS-1:0] dsr_in [0:hcc_pkg::DIV_STAGES-1];

   // The quotient always fits, so the top dividend bits are already below the divisor.
   always_comb begin
      logic [hcc_pkg::CHANNEL_BITS-1:0] rem_p;
      logic [hcc_pkg::QUO_W-1:0]        quo_p;
      logic [hcc_pkg::QUO_W-1:0]        low_p;
      logic [hcc_pkg::CHANNEL_BITS-1:0] dsr_p;
      logic [hcc_pkg::CHANNEL_BITS:0]   trial;
      logic                             ge;
      for (int k = 0; k < hcc_pkg::DIV_STAGES; k++) begin
         if (k == 0) begin
            rem_p = dividend[hcc_pkg::DVD_W-1:hcc_pkg::QUO_W];
            quo_p = '0;
            low_p = dividend[hcc_pkg::QUO_W-1:0];
            dsr_p = divisor;
         end else begin
            rem_p = rem_ff[k-1];
            quo_p = quo_ff[k-1];
            low_p = low_ff[k-1];
            dsr_p = dsr_ff[k-1];
         end
         trial = {rem_p, low_p[hcc_pkg::QUO_W-1]};
         ge    = (trial >= {1'b0, dsr_p});
         if (ge) begin
            rem_in[k] = hcc_pkg::CHANNEL_BITS'(trial - {1'b0, dsr_p});
         end else begin
            rem_in[k] = trial[hcc_pkg::CHANNEL_BITS-1:0];
         end
         quo_in[k] = {quo_p[hcc_pkg::QUO_W-2:0], ge};
         low_in[k] = {low_p[hcc_pkg::QUO_W-2:0], 1'b0};
         dsr_in[k] = dsr_p;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < hcc_pkg::DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            low_ff[k] <= low_in[k];
            dsr_ff[k] <= dsr_in[k];
         end
      end
   end

   assign quotient = quo_ff[hcc_pkg::DIV_STAGES-1];

endmodule

/* rtl/hsv_color_classifier_core.sv */
// Top level of the HSV colour classifier: channel correction, HSV pipeline and classification.
//
//   channel   ports                              direction  carries
//   request   req_valid, req_ready, req_data     in         one raw sensor reading
//   response  rsp_valid, rsp_ready, rsp_data     out        class, hue, saturation, value
//   config    psel, penable, pwrite, paddr, ...  in/out     black_mode register
//
// Each request is caught in an input register at its accepting edge, then passes a correction
// stage, an HSV numerator stage, 17 divider stages (one quotient bit each, set by the Q0.16
// saturation width) and an output register. One request is accepted every cycle while the
// response is not held.
// Reset clears every valid bit and black_mode. When the response is held, the whole pipeline
// freezes in place, so no request is lost or repeated.
module hsv_color_classifier_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  hcc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output hcc_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [hcc_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic black_mode_ff;
   logic advance;

   // Stage 0: the raw request.
   logic             s0_valid_ff;
   hcc_pkg::req_type s0_ff;

   // Stage 1: corrected and clamped channels.
   logic                             s1_valid_ff;
   logic [hcc_pkg::CHANNEL_BITS-1:0] s1_r_ff, s1_g_ff, s1_b_ff, s1_scale_ff;
   logic [hcc_pkg::CHANNEL_BITS-1:0] s1_r_in, s1_g_in, s1_b_in, s1_scale_in;
   logic                             s1_env_ff, s1_env_in;

   // Stage 2: dividends and divisors for value, saturation and hue.
   hcc_pkg::side_type                s2_side_ff, s2_side_in;
   logic [hcc_pkg::DVD_W-1:0]        s2_dvd_v_ff, s2_dvd_s_ff, s2_dvd_h_ff;
   logic [hcc_pkg::DVD_W-1:0]        s2_dvd_v_in, s2_dvd_s_in, s2_dvd_h_in;
   logic [hcc_pkg::CHANNEL_BITS-1:0] s2_dsr_v_ff, s2_dsr_s_ff, s2_dsr_h_ff;
   logic [hcc_pkg::CHANNEL_BITS-1:0] s2_dsr_v_in, s2_dsr_s_in, s2_dsr_h_in;

   hcc_pkg::side_type         side_ff [0:hcc_pkg::DIV_STAGES-1];
   logic [hcc_pkg::QUO_W-1:0] quo_v, quo_s, quo_h;

   logic             rsp_valid_ff;
   hcc_pkg::rsp_type rsp_ff, rsp_in;

   // The pipeline moves as one whenever the output register is free or being emptied.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration port: single register, no wait states.
   assign pready = 1'b1;
   assign prdata = {31'b0, black_mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         black_mode_ff <= 1'b0;
      end else if (psel && penable && pwrite && paddr[2] == hcc_pkg::REG_BLACK_MODE) begin
         black_mode_ff <= pwdata[0];
      end
   end

   // Stage 1: ambient is added to each channel, the scale is chosen from the largest sum and
   // each channel is clamped to it. The ambient ratio test is settled here from the raw values,
   // with the mean of the three channels taken by a reciprocal multiply.
   always_comb begin
      logic [hcc_pkg::CHANNEL_BITS:0]   r_sum, g_sum, b_sum, mx;
      logic [hcc_pkg::CHANNEL_BITS+1:0] tot;
      logic [hcc_pkg::CHANNEL_BITS+1+hcc_pkg::MEAN_MUL_W:0] prod;
      logic [hcc_pkg::CHANNEL_BITS-1:0] mean;
      logic [hcc_pkg::CHANNEL_BITS+3:0] lhs, rhs;
      r_sum = {1'b0, s0_ff.red_raw} + {1'b0, s0_ff.ambient_raw};
      g_sum = {1'b0, s0_ff.green_raw} + {1'b0, s0_ff.ambient_raw};
      b_sum = {1'b0, s0_ff.blue_raw} + {1'b0, s0_ff.ambient_raw};
      mx = (r_sum > g_sum) ? r_sum : g_sum;
      mx = (mx > b_sum) ? mx : b_sum;
      s1_scale_in = (mx > hcc_pkg::SCALE_SWITCH) ? hcc_pkg::SCALE_HI : hcc_pkg::SCALE_LO;
      s1_r_in = (r_sum > {1'b0, s1_scale_in}) ? s1_scale_in
                                              : r_sum[hcc_pkg::CHANNEL_BITS-1:0];
      s1_g_in = (g_sum > {1'b0, s1_scale_in}) ? s1_scale_in
                                              : g_sum[hcc_pkg::CHANNEL_BITS-1:0];
      s1_b_in = (b_sum > {1'b0, s1_scale_in}) ? s1_scale_in
                                              : b_sum[hcc_pkg::CHANNEL_BITS-1:0];
      tot  = (hcc_pkg::CHANNEL_BITS + 2)'(s0_ff.red_raw)
           + (hcc_pkg::CHANNEL_BITS + 2)'(s0_ff.green_raw)
           + (hcc_pkg::CHANNEL_BITS + 2)'(s0_ff.blue_raw);
      prod = ($bits(prod))'(tot) * ($bits(prod))'(hcc_pkg::MEAN_MUL);
      mean = hcc_pkg::CHANNEL_BITS'(prod >> hcc_pkg::MEAN_SHIFT);
      lhs  = ($bits(lhs))'(s0_ff.ambient_raw) * ($bits(lhs))'(10);
      rhs  = (($bits(rhs))'(mean) + ($bits(rhs))'(s0_ff.ambient_raw)) * ($bits(rhs))'(3);
      s1_env_in = (lhs > rhs);
   end

   // Stage 2: largest and smallest channel, chroma and the hue numerator of the sector that the
   // largest channel picks, red first, then green, then blue.
   always_comb begin
      logic [hcc_pkg::CHANNEL_BITS-1:0] v, m, c;
      logic [hcc_pkg::NUM_W-1:0]        num, c_n;
      v = (s1_r_ff > s1_g_ff) ? s1_r_ff : s1_g_ff;
      v = (v > s1_b_ff) ? v : s1_b_ff;
      m = (s1_r_ff < s1_g_ff) ? s1_r_ff : s1_g_ff;
      m = (m < s1_b_ff) ? m : s1_b_ff;
      c = v - m;
      c_n = hcc_pkg::NUM_W'(c);
      if (v == s1_r_ff) begin
         if (s1_g_ff >= s1_b_ff) begin
            num = hcc_pkg::NUM_W'(60) * hcc_pkg::NUM_W'(s1_g_ff - s1_b_ff);
         end else begin
            num = hcc_pkg::NUM_W'(360) * c_n
                - hcc_pkg::NUM_W'(60) * hcc_pkg::NUM_W'(s1_b_ff - s1_g_ff);
         end
      end else if (v == s1_g_ff) begin
         num = hcc_pkg::NUM_W'(120) * c_n + hcc_pkg::NUM_W'(60) * hcc_pkg::NUM_W'(s1_b_ff)
             - hcc_pkg::NUM_W'(60) * hcc_pkg::NUM_W'(s1_r_ff);
      end else begin
         num = hcc_pkg::NUM_W'(240) * c_n + hcc_pkg::NUM_W'(60) * hcc_pkg::NUM_W'(s1_r_ff)
             - hcc_pkg::NUM_W'(60) * hcc_pkg::NUM_W'(s1_g_ff);
      end
      s2_dvd_v_in = hcc_pkg::DVD_W'(v) << hcc_pkg::FRAC_BITS;
      s2_dvd_s_in = hcc_pkg::DVD_W'(c) << hcc_pkg::FRAC_BITS;
      s2_dvd_h_in = hcc_pkg::DVD_W'(num) << hcc_pkg::HUE_FRAC;
      s2_dsr_v_in = s1_scale_ff;
      s2_dsr_s_in = v;
      s2_dsr_h_in = c;
      s2_side_in.valid  = s1_valid_ff;
      s2_side_in.env_hi = s1_env_ff;
      s2_side_in.gray   = (c == '0);
      s2_side_in.dark   = (v == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_side_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < hcc_pkg::DIV_STAGES; k++) begin
            side_ff[k] <= '0;
         end
      end else if (advance) begin
         s0_valid_ff  <= req_valid;
         s1_valid_ff  <= s0_valid_ff;
         s2_side_ff   <= s2_side_in;
         side_ff[0]   <= s2_side_ff;
         for (int k = 1; k < hcc_pkg::DIV_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         rsp_valid_ff <= side_ff[hcc_pkg::DIV_STAGES-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff       <= req_data;
         s1_r_ff     <= s1_r_in;
         s1_g_ff     <= s1_g_in;
         s1_b_ff     <= s1_b_in;
         s1_scale_ff <= s1_scale_in;
         s1_env_ff   <= s1_env_in;
         s2_dvd_v_ff <= s2_dvd_v_in;
         s2_dvd_s_ff <= s2_dvd_s_in;
         s2_dvd_h_ff <= s2_dvd_h_in;
         s2_dsr_v_ff <= s2_dsr_v_in;
         s2_dsr_s_ff <= s2_dsr_s_in;
         s2_dsr_h_ff <= s2_dsr_h_in;
         rsp_ff      <= rsp_in;
      end
   end

   // Three dividers run side by side: value over scale, chroma over value, hue numerator over
   // chroma. Their results line up with the last entry of the side pipeline.
   hcc_divider u_div_value (
      .clock    (clock),
      .enable   (advance),
      .dividend (s2_dvd_v_ff),
      .divisor  (s2_dsr_v_ff),
      .quotient (quo_v)
   );

   hcc_divider u_div_sat (
      .clock    (clock),
      .enable   (advance),
      .dividend (s2_dvd_s_ff),
      .divisor  (s2_dsr_s_ff),
      .quotient (quo_s)
   );

   hcc_divider u_div_hue (
      .clock    (clock),
      .enable   (advance),
      .dividend (s2_dvd_h_ff),
      .divisor  (s2_dsr_h_ff),
      .quotient (quo_h)
   );

   // Final stage: saturate the fractions, patch the gray and dark cases, then classify. A gray
   // reading has no meaningful hue and reports 359 degrees; its hue divider output is ignored.
   always_comb begin
      hcc_pkg::side_type            sd;
      logic [hcc_pkg::FRAC_BITS-1:0] vq, sq, vblack;
      logic [hcc_pkg::HUE_BITS-1:0]  hq;
      hcc_pkg::color_class_type      cls;
      sd = side_ff[hcc_pkg::DIV_STAGES-1];
      vq = (quo_v > hcc_pkg::QUO_W'(hcc_pkg::QMAX)) ? hcc_pkg::QMAX
                                                     : quo_v[hcc_pkg::FRAC_BITS-1:0];
      if (sd.dark) begin
         sq = '0;
      end else begin
         sq = (quo_s > hcc_pkg::QUO_W'(hcc_pkg::QMAX)) ? hcc_pkg::QMAX
                                                        : quo_s[hcc_pkg::FRAC_BITS-1:0];
      end
      hq = sd.gray ? hcc_pkg::DEG_359 : quo_h[hcc_pkg::HUE_BITS-1:0];
      vblack = black_mode_ff ? hcc_pkg::THR_15 : hcc_pkg::THR_18;

      if (vq <= vblack) begin
         cls = hcc_pkg::CLS_BLACK;
      end else if (sq <= hcc_pkg::THR_18 && vq >= hcc_pkg::THR_75) begin
         cls = hcc_pkg::CLS_WHITE;
      end else if (sq < hcc_pkg::THR_15) begin
         cls = hcc_pkg::CLS_UNKNOWN;
      end else if (hq < hcc_pkg::DEG_25 || hq >= hcc_pkg::DEG_335) begin
         cls = hcc_pkg::CLS_RED;
      end else if (hq < hcc_pkg::DEG_70) begin
         // Yellow band: bright washed-out readings under strong ambient light are white, the
         // top of the band is green and dim unsaturated readings are black.
         if (vq >= hcc_pkg::THR_55 && sq <= hcc_pkg::THR_50 && sd.env_hi) begin
            cls = hcc_pkg::CLS_WHITE;
         end else if (hq >= hcc_pkg::DEG_60) begin
            cls = hcc_pkg::CLS_GREEN;
         end else if (vq <= hcc_pkg::THR_30 && sq <= hcc_pkg::THR_35) begin
            cls = hcc_pkg::CLS_BLACK;
         end else begin
            cls = hcc_pkg::CLS_YELLOW;
         end
      end else if (hq < hcc_pkg::DEG_170) begin
         cls = hcc_pkg::CLS_GREEN;
      end else if (hq < hcc_pkg::DEG_190) begin
         // Between green and blue: only the lower edge itself counts as green.
         cls = (hq == hcc_pkg::DEG_170) ? hcc_pkg::CLS_GREEN : hcc_pkg::CLS_BLUE;
      end else if (hq < hcc_pkg::DEG_260) begin
         cls = hcc_pkg::CLS_BLUE;
      end else begin
         // Between blue and red: up to 290 degrees is blue, above it red.
         cls = (hq <= hcc_pkg::DEG_290) ? hcc_pkg::CLS_BLUE : hcc_pkg::CLS_RED;
      end

      rsp_in.color_class      = cls;
      rsp_in.hue_deg          = hq;
      rsp_in.saturation       = sq;
      rsp_in.brightness_value = vq;
   end

endmodule

/* sim/hsv_color_classifier_core_tb.sv */
// Self-checking testbench for the HSV colour classifier core with a scoreboard class.
module hsv_color_classifier_core_tb;
   import hcc_pkg::*;

   // Scoreboard: predicts the response of each accepted request and checks responses in order.
   class hsv_scoreboard;
      rsp_type pending_q[$];
      bit      black_mode;
      int      mismatch_count;
      int      unexpected_count;

      function rsp_type classify_reading(req_type rd);
         rsp_type    res;
         int unsigned r0, g0, b0, amb, r, g, b, scale, vmax, vmin, chroma;
         int unsigned vq, sq, hq, num, mean, vblack;
         bit          env_hi;
         color_class_type cls;
         r0 = 32'(rd.red_raw);
         g0 = 32'(rd.green_raw);
         b0 = 32'(rd.blue_raw);
         amb = 32'(rd.ambient_raw);
         r = r0 + amb;
         g = g0 + amb;
         b = b0 + amb;
         vmax = (r > g) ? r : g;
         vmax = (vmax > b) ? vmax : b;
         scale = (vmax > 320) ? 1023 : 255;
         if (r > scale) r = scale;
         if (g > scale) g = scale;
         if (b > scale) b = scale;
         vmax = (r > g) ? r : g;
         vmax = (vmax > b) ? vmax : b;
         vmin = (r < g) ? r : g;
         vmin = (vmin < b) ? vmin : b;
         chroma = vmax - vmin;
         vq = (vmax << 16) / scale;
         if (vq > 65535) vq = 65535;
         sq = (vmax != 0) ? (chroma << 16) / vmax : 0;
         if (sq > 65535) sq = 65535;
         if (chroma == 0) begin
            hq = 359 << 7;
         end else begin
            // The sector follows the largest channel; ties go to red, then green.
            if (vmax == r)
               num = (g >= b) ? 60 * (g - b) : 360 * chroma - 60 * (b - g);
            else if (vmax == g)
               num = 120 * chroma + 60 * b - 60 * r;
            else
               num = 240 * chroma + 60 * r - 60 * g;
            hq = (num << 7) / chroma;
         end
         mean = (r0 + g0 + b0) / 3;
         env_hi = (10 * amb) > (3 * (mean + amb));
         vblack = black_mode ? 9830 : 11796;
         if (vq <= vblack) cls = CLS_BLACK;
         else if (sq <= 11796 && vq >= 49152) cls = CLS_WHITE;
         else if (sq < 9830) cls = CLS_UNKNOWN;
         else if (hq < (25 << 7) || hq >= (335 << 7)) cls = CLS_RED;
         else if (hq < (70 << 7)) begin
            if (vq >= 36044 && sq <= 32768 && env_hi) cls = CLS_WHITE;
            else if (hq >= (60 << 7)) cls = CLS_GREEN;
            else if (vq <= 19660 && sq <= 22937) cls = CLS_BLACK;
            else cls = CLS_YELLOW;
         end
         else if (hq < (170 << 7)) cls = CLS_GREEN;
         else if (hq < (190 << 7)) cls = (hq == (170 << 7)) ? CLS_GREEN : CLS_BLUE;
         else if (hq < (260 << 7)) cls = CLS_BLUE;
         else cls = (hq <= (290 << 7)) ? CLS_BLUE : CLS_RED;
         res.color_class = cls;
         res.hue_deg = hq[15:0];
         res.saturation = sq[15:0];
         res.brightness_value = vq[15:0];
         return res;
      endfunction

      function void note_request(req_type rd);
         pending_q.push_back(classify_reading(rd));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= 10)
               $display("unexpected response %h", got);
            return;
         end
         want = pending_q.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count + unexpected_count <= 10) begin
               $write("mismatch: expected cls %0d hue %0d sat %0d val %0d, ",
                      want.color_class, want.hue_deg, want.saturation, want.brightness_value);
               $display("got cls %0d hue %0d sat %0d val %0d",
                        got.color_class, got.hue_deg, got.saturation, got.brightness_value);
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   hsv_scoreboard scoreboard;
   int            send_idle_pct;
   int            stall_pct;

   hsv_color_classifier_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Safety net: far beyond the slowest correct run with both sides idling.
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Responses are sampled at the rising edge; ready is re-rolled at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         scoreboard.check_response(rsp_data);
   end

   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Sends one request, holding it until accepted, with an optional idle gap first. Valid stays
   // high after acceptance so that back-to-back requests follow without a gap.
   task automatic send_reading(input req_type rd);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scoreboard.note_request(rd);
      @(negedge clock);
   endtask

   task automatic send_rgba(input int r, input int g, input int b, input int a);
      req_type rd;
      rd.red_raw = FIELD_BITS'(r);
      rd.green_raw = FIELD_BITS'(g);
      rd.blue_raw = FIELD_BITS'(b);
      rd.ambient_raw = FIELD_BITS'(a);
      send_reading(rd);
   endtask

   // Waits until every expected response is back, then lets the pipeline drain fully.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (scoreboard.pending_q.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_black_mode(input bit mode);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= '0;
      pwdata <= {31'd0, mode};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      scoreboard.black_mode = mode;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Mostly small readings with some bright ones, so both scales and all hue bands are hit.
   task automatic send_random_reading();
      req_type rd;
      int      pick;
      pick = $urandom_range(9);
      if (pick < 5) begin
         rd.red_raw = FIELD_BITS'($urandom_range(300));
         rd.green_raw = FIELD_BITS'($urandom_range(300));
         rd.blue_raw = FIELD_BITS'($urandom_range(300));
         rd.ambient_raw = FIELD_BITS'($urandom_range(40));
      end else if (pick < 8) begin
         rd.red_raw = FIELD_BITS'($urandom_range(1023));
         rd.green_raw = FIELD_BITS'($urandom_range(1023));
         rd.blue_raw = FIELD_BITS'($urandom_range(1023));
         rd.ambient_raw = FIELD_BITS'($urandom_range(1023));
      end else begin
         rd.red_raw = FIELD_BITS'($urandom_range(255));
         rd.green_raw = rd.red_raw + FIELD_BITS'($urandom_range(8));
         rd.blue_raw = rd.red_raw + FIELD_BITS'($urandom_range(8));
         rd.ambient_raw = FIELD_BITS'($urandom_range(255));
      end
      send_reading(rd);
   endtask

   initial begin
      int phase_idx;
      scoreboard = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed readings: extremes, gray, every hue band, the 60 degree edge and the scale switch.
      write_black_mode(1'b0);
      send_rgba(0, 0, 0, 0);
      send_rgba(1023, 1023, 1023, 1023);
      send_rgba(1023, 0, 0, 0);
      send_rgba(0, 1023, 0, 0);
      send_rgba(0, 0, 1023, 0);
      send_rgba(200, 200, 200, 0);
      send_rgba(320, 0, 0, 0);
      send_rgba(321, 0, 0, 0);
      send_rgba(255, 255, 0, 0);
      send_rgba(255, 170, 0, 0);
      send_rgba(255, 255, 40, 0);
      send_rgba(60, 50, 20, 0);
      send_rgba(0, 255, 255, 0);
      send_rgba(0, 85, 255, 0);
      send_rgba(170, 0, 255, 0);
      send_rgba(255, 0, 128, 0);
      send_rgba(180, 160, 100, 400);
      send_rgba(40, 10, 10, 0);
      send_rgba(200, 120, 40, 100);
      send_rgba(100, 100, 90, 0);
      send_rgba(0, 0, 0, 1023);
      wait_drained();
      write_black_mode(1'b1);
      send_rgba(40, 10, 10, 0);
      send_rgba(45, 30, 10, 0);
      send_rgba(0, 0, 0, 0);

      // Random phases: none, sender idle, receiver stalling, both; black_mode varies.
      for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
         wait_drained();
         write_black_mode(phase_idx[0]);
         case (phase_idx % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 51; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         repeat (180) send_random_reading();
      end

      wait_drained();
      if (scoreboard.mismatch_count == 0 && scoreboard.unexpected_count == 0 &&
          scoreboard.pending_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/hcc_pkg.sv
rtl/hcc_divider.sv
rtl/hsv_color_classifier_core.sv
sim/hsv_color_classifier_core_tb.sv
